[src/cartridge_bank_mapper_defines.svh]
// Assertion macros shared by the bank mapper RTL.
// Depends on nothing; files that assert include it inside their module body.
`ifndef CARTRIDGE_BANK_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_DEFINES_SVH

// Immediate implication: cons must hold in the cycle where ante holds.
`define CBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cbm_pkg.sv]
// Shared constants and types of the cartridge bank mapper.
// Used by cbm_regs and cartridge_bank_mapper; depends on nothing.
package cbm_pkg;

    localparam int RAM_BANKS_DEF  = 16;
    localparam int ROM_BANKS_DEF  = 512;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_OFF_W      = 13;
    localparam int RAM_FULL_W     = 8 + RAM_OFF_W;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ROM_BANK_COUNT = 2'd0;
    localparam logic [1:0] REG_RAM_BANK_COUNT = 2'd1;
    localparam logic [1:0] REG_HAS_RUMBLE     = 2'd2;

    localparam logic [9:0] ROM_COUNT_RESET = 10'd2;

    // bus decode
    localparam logic [15:0] ADDR_RAMEN_END   = 16'h1FFF;
    localparam logic [15:0] ADDR_ROMLO_END   = 16'h2FFF;
    localparam logic [15:0] ADDR_ROMHI_END   = 16'h3FFF;
    localparam logic [15:0] ADDR_RAMSEL_END  = 16'h5FFF;
    localparam logic [15:0] ADDR_ROM1_END    = 16'h7FFF;
    localparam logic [15:0] ADDR_RAM_START   = 16'hA000;
    localparam logic [15:0] ADDR_RAM_END     = 16'hBFFF;

    localparam logic [7:0] RAM_ENABLE_KEY  = 8'h0A;
    localparam logic [7:0] LOW_NIBBLE_MASK = 8'b0000_1111;
    localparam logic [7:0] BIT0_MASK       = 8'b0000_0001;
    localparam logic [7:0] RUMBLE_MASK     = 8'b0000_1000;
    localparam logic [7:0] OPEN_BUS        = 8'hFF;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_fetch;
        logic [22:0] rom_address;
        logic        rumble_on;
        logic        use_ram;
    } res_t;

    typedef struct packed {
        logic                  en;
        logic                  we;
        logic [RAM_FULL_W-1:0] addr;
        logic [7:0]            wdata;
    } ram_req_t;

endpackage

[src/cbm_ram.sv]
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/cbm_regs.sv]
// Configuration registers, bank registers and bus access decode.
// Depends on cbm_pkg; feeds a result and a RAM request to the top level.
module cbm_regs #(
    parameter int RAM_BANKS = cbm_pkg::RAM_BANKS_DEF,
    parameter int ROM_BANKS = cbm_pkg::ROM_BANKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    input  logic              accept,
    input  logic              mode,
    input  logic [15:0]       address,
    input  logic [7:0]        write_data,
    output cbm_pkg::res_t     res,
    output cbm_pkg::ram_req_t ram_req
);
    import cbm_pkg::*;

    logic [9:0] rom_bank_count_reg;
    logic [4:0] ram_bank_count_reg;
    logic       has_rumble_reg;

    logic [7:0] rom_bank_low_reg, rom_bank_low_next;
    logic       rom_bank_high_reg, rom_bank_high_next;
    logic [7:0] ram_bank_select_reg, ram_bank_select_next;
    logic       ram_enabled_reg, ram_enabled_next;
    logic       motor_level_reg, motor_level_next;

    logic [8:0] rom_bank;
    logic       rom_ok;
    logic       ram_ok;
    logic       in_ram;
    logic       cfg_write;

    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_count_reg <= ROM_COUNT_RESET;
            ram_bank_count_reg <= '0;
            has_rumble_reg     <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_ROM_BANK_COUNT: rom_bank_count_reg <= pwdata[9:0];
                REG_RAM_BANK_COUNT: ram_bank_count_reg <= pwdata[4:0];
                REG_HAS_RUMBLE:     has_rumble_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROM_BANK_COUNT: prdata = {22'd0, rom_bank_count_reg};
            REG_RAM_BANK_COUNT: prdata = {27'd0, ram_bank_count_reg};
            REG_HAS_RUMBLE:     prdata = {31'd0, has_rumble_reg};
            default:            prdata = '0;
        endcase
    end

    assign rom_bank = {rom_bank_high_reg, rom_bank_low_reg};
    assign rom_ok   = ({1'b0, rom_bank} < rom_bank_count_reg)
                   && ({1'b0, rom_bank} < 10'(ROM_BANKS));
    assign ram_ok   = ram_enabled_reg
                   && (ram_bank_select_reg < {3'd0, ram_bank_count_reg})
                   && (ram_bank_select_reg < 8'(RAM_BANKS));
    assign in_ram   = (address >= ADDR_RAM_START) && (address <= ADDR_RAM_END);

    always_comb begin
        rom_bank_low_next    = rom_bank_low_reg;
        rom_bank_high_next   = rom_bank_high_reg;
        ram_bank_select_next = ram_bank_select_reg;
        ram_enabled_next     = ram_enabled_reg;
        motor_level_next     = motor_level_reg;
        res                  = '0;
        ram_req.en           = 1'b0;
        ram_req.we           = mode;
        ram_req.addr         = {ram_bank_select_reg, address[RAM_OFF_W-1:0]};
        ram_req.wdata        = write_data;

        if (mode == MODE_WRITE) begin
            priority if (address <= ADDR_RAMEN_END) begin
                ram_enabled_next = (write_data & LOW_NIBBLE_MASK) == RAM_ENABLE_KEY;
            end else if (address <= ADDR_ROMLO_END) begin
                rom_bank_low_next = write_data;
            end else if (address <= ADDR_ROMHI_END) begin
                rom_bank_high_next = (write_data & BIT0_MASK) != 8'd0;
            end else if (address <= ADDR_RAMSEL_END) begin
                ram_bank_select_next = write_data;
                if (has_rumble_reg) begin
                    motor_level_next = (write_data & RUMBLE_MASK) != 8'd0;
                end
            end else if (in_ram && ram_ok) begin
                ram_req.en = accept;
            end else begin
                // unmapped write: drop
            end
        end else begin
            priority if (address <= ADDR_ROMHI_END) begin
                res.rom_fetch   = 1'b1;
                res.rom_address = {9'd0, address[13:0]};
            end else if (address <= ADDR_ROM1_END) begin
                if (rom_ok) begin
                    res.rom_fetch   = 1'b1;
                    res.rom_address = {rom_bank, address[13:0]};
                end else begin
                    res.read_data = OPEN_BUS;
                end
            end else if (in_ram && ram_ok) begin
                res.use_ram = 1'b1;
                ram_req.en  = accept;
            end else begin
                res.read_data = OPEN_BUS;
            end
        end
        res.rumble_on = motor_level_next & has_rumble_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_low_reg    <= 8'd1;
            rom_bank_high_reg   <= 1'b0;
            ram_bank_select_reg <= '0;
            ram_enabled_reg     <= 1'b0;
            motor_level_reg     <= 1'b0;
        end else if (accept) begin
            rom_bank_low_reg    <= rom_bank_low_next;
            rom_bank_high_reg   <= rom_bank_high_next;
            ram_bank_select_reg <= ram_bank_select_next;
            ram_enabled_reg     <= ram_enabled_next;
            motor_level_reg     <= motor_level_next;
        end
    end

endmodule

[src/cartridge_bank_mapper.sv]
// Cartridge bank mapper: one CPU bus access per input item, one result item
// per access. The block takes one item every clock cycle while the result side
// keeps up; an accepted item waits in stage 1, where the registered read data of
// the cartridge RAM arrives, and then moves into the output register. The
// cartridge RAM sits in a single-port memory (RAM_BANKS x 8 KiB) with no reset;
// a RAM read of a byte never written returns an arbitrary value. No clearing
// pass is needed. No item is taken during reset.
// Depends on cbm_pkg, cbm_regs, cbm_ram and cartridge_bank_mapper_defines.svh.
module cartridge_bank_mapper #(
    parameter int RAM_BANKS = cbm_pkg::RAM_BANKS_DEF,
    parameter int ROM_BANKS = cbm_pkg::ROM_BANKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // bus accesses
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic        s_tuser,   // [0] mode
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] read_data, [30:8] rom_address, [31] rumble_on
    output logic        m_tuser    // [0] rom_fetch
);
    import cbm_pkg::*;
    `include "cartridge_bank_mapper_defines.svh"

    localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    res_t     res;
    ram_req_t ram_req;
    logic [7:0] ram_rdata;

    logic accept;
    logic adv1;

    logic        st1_valid_reg;
    res_t        st1_reg;
    logic        m_valid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic [7:0]  st1_read_data;

    assign pready   = 1'b1;
    assign adv1     = !m_valid_reg || m_tready;
    assign s_tready = aresetn && (!st1_valid_reg || adv1);
    assign accept   = s_tvalid && s_tready;

    cbm_regs #(
        .RAM_BANKS (RAM_BANKS),
        .ROM_BANKS (ROM_BANKS)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .accept     (accept),
        .mode       (s_tuser),
        .address    (s_tdata[15:0]),
        .write_data (s_tdata[23:16]),
        .res        (res),
        .ram_req    (ram_req)
    );

    cbm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_cart_ram (
        .aclk  (aclk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr[RAM_AW-1:0]),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // RAM data arrives while the item sits in stage 1
    assign st1_read_data = st1_reg.use_ram ? ram_rdata : st1_reg.read_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_tready) begin
                st1_valid_reg <= s_tvalid;
            end
            if (adv1) begin
                m_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg <= res;
        end
        if (adv1 && st1_valid_reg) begin
            m_tdata_reg <= {st1_reg.rumble_on, st1_reg.rom_address, st1_read_data};
            m_tuser_reg <= st1_reg.rom_fetch;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CBM_ASSERT_NEXT(a_st1_holds, st1_valid_reg && !adv1, st1_valid_reg && $stable(st1_reg), "stage 1 item lost while output stalled")
    `CBM_ASSERT_NEXT(a_ram_read_tracked, ram_req.en && !ram_req.we, st1_valid_reg && st1_reg.use_ram, "RAM read issued without a matching stage 1 item")
    `CBM_ASSERT_NOW(a_fetch_no_data, m_valid_reg && m_tuser_reg, m_tdata_reg[7:0] == 8'd0, "ROM fetch result carries RAM data")

endmodule

[verif/testbench.sv]
// Self-checking testbench for cartridge_bank_mapper: a directed table, then random bus
// accesses under several mapper settings, each result checked against a predictor.
// Depends on cbm_pkg and the cartridge_bank_mapper RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam int RAM_BYTES   = RAM_BANKS_DEF * RAM_BANK_BYTES;
    localparam int HOT_SLOTS   = 24;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 6;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 125;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic        mode;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } bus_access_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_fetch;
        logic [22:0] rom_address;
        logic        rumble_on;
    } bus_result_t;

    typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        bus_access_t acc;
        bit          typed;
        bus_result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] address, [23:16] write_data
    logic        s_tuser;   // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [7:0] read_data, [30:8] rom_address, [31] rumble_on
    logic        m_tuser;   // [0] rom_fetch

    cartridge_bank_mapper dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // mapper copy: settings and bank state
    logic [9:0]  cfg_rom_count;
    logic [4:0]  cfg_ram_count;
    logic        cfg_rumble;
    logic [7:0]  bank_lo;
    logic        bank_hi;
    logic [7:0]  ram_sel;
    logic        ram_en;
    logic        motor;
    logic [7:0]  cart_ram [RAM_BYTES];
    bit          ram_written [RAM_BYTES];
    logic [12:0] hot_offsets [HOT_SLOTS];

    bus_result_t pending_results[$];
    bit          cur_typed;
    bus_result_t cur_want;
    bit          hold_off_req;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned stall_mode;
    int unsigned rx_phase;
    int unsigned idle_cycles;

    int unsigned n_errors;
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_fetches;
    int unsigned n_ram_data;
    int unsigned n_open_bus;
    int unsigned n_cfg_writes;

    stim_row_t   directed[$];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned rom_limit();
        return (cfg_rom_count < ROM_BANKS_DEF) ? cfg_rom_count : ROM_BANKS_DEF;
    endfunction

    function automatic bit ram_ready();
        int unsigned lim;
        lim = (cfg_ram_count < RAM_BANKS_DEF) ? cfg_ram_count : RAM_BANKS_DEF;
        return ram_en && (ram_sel < lim);
    endfunction

    function automatic int unsigned ram_slot(logic [15:0] addr);
        return ram_sel * RAM_BANK_BYTES + addr[RAM_OFF_W-1:0];
    endfunction

    function automatic bit in_ram_window(logic [15:0] addr);
        return (addr >= ADDR_RAM_START) && (addr <= ADDR_RAM_END);
    endfunction

    function automatic void reset_mapping();
        cfg_rom_count = ROM_COUNT_RESET;
        cfg_ram_count = '0;
        cfg_rumble    = 1'b0;
        bank_lo       = 8'd1;
        bank_hi       = 1'b0;
        ram_sel       = '0;
        ram_en        = 1'b0;
        motor         = 1'b0;
    endfunction

    function automatic void set_register(logic [1:0] idx, logic [31:0] val);
        case (idx)
            REG_ROM_BANK_COUNT: cfg_rom_count = val[9:0];
            REG_RAM_BANK_COUNT: cfg_ram_count = val[4:0];
            REG_HAS_RUMBLE:     cfg_rumble    = val[0];
            default: ;
        endcase
    endfunction

    // Apply one bus access to the mapper copy and return what the block must answer.
    function automatic bus_result_t map_access(bus_access_t a);
        bus_result_t r;
        logic [8:0]  bank;
        r = '0;
        if (a.mode == MODE_WRITE) begin
            if (a.addr <= ADDR_RAMEN_END) begin
                ram_en = (a.wdata & LOW_NIBBLE_MASK) == RAM_ENABLE_KEY;
            end else if (a.addr <= ADDR_ROMLO_END) begin
                bank_lo = a.wdata;
            end else if (a.addr <= ADDR_ROMHI_END) begin
                bank_hi = (a.wdata & BIT0_MASK) != '0;
            end else if (a.addr <= ADDR_RAMSEL_END) begin
                ram_sel = a.wdata;
                if (cfg_rumble)
                    motor = (a.wdata & RUMBLE_MASK) != '0;
            end else if (in_ram_window(a.addr) && ram_ready()) begin
                cart_ram[ram_slot(a.addr)]    = a.wdata;
                ram_written[ram_slot(a.addr)] = 1'b1;
            end
        end else begin
            if (a.addr <= ADDR_ROMHI_END) begin
                r.rom_fetch   = 1'b1;
                r.rom_address = 23'(a.addr);
            end else if (a.addr <= ADDR_ROM1_END) begin
                bank = {bank_hi, bank_lo};
                if (bank < rom_limit()) begin
                    // bank times 16 KiB plus the offset inside the window
                    r.rom_fetch   = 1'b1;
                    r.rom_address = {bank, a.addr[13:0]};
                end else begin
                    r.read_data = OPEN_BUS;
                end
            end else if (in_ram_window(a.addr) && ram_ready()) begin
                r.read_data = cart_ram[ram_slot(a.addr)];
                n_ram_data++;
            end else begin
                r.read_data = OPEN_BUS;
            end
            if (r.rom_fetch)
                n_fetches++;
            else if (r.read_data == OPEN_BUS)
                n_open_bus++;
        end
        r.rumble_on = motor & cfg_rumble;
        return r;
    endfunction

    // Draw a random access, mostly well-formed mapper traffic, some noise.
    function automatic bus_access_t pick_access();
        bus_access_t a;
        int unsigned roll;
        logic [12:0] off;
        a.mode  = MODE_WRITE;
        a.wdata = 8'($urandom_range(0, 255));
        roll    = $urandom_range(0, 99);
        off = ($urandom_range(0, 3) != 0) ? hot_offsets[$urandom_range(0, HOT_SLOTS - 1)]
                                          : 13'($urandom);
        if (roll < 10) begin
            a.addr = 16'($urandom_range(0, ADDR_RAMEN_END));
            if ($urandom_range(0, 3) != 0)
                a.wdata[3:0] = RAM_ENABLE_KEY[3:0];
        end else if (roll < 17) begin
            a.addr = 16'($urandom_range(ADDR_RAMEN_END + 1, ADDR_ROMLO_END));
            if ($urandom_range(0, 2) != 0)
                a.wdata = 8'($urandom_range(0, rom_limit() - 1));
        end else if (roll < 22) begin
            a.addr = 16'($urandom_range(ADDR_ROMLO_END + 1, ADDR_ROMHI_END));
        end else if (roll < 30) begin
            a.addr = 16'($urandom_range(ADDR_ROMHI_END + 1, ADDR_RAMSEL_END));
            if ($urandom_range(0, 3) != 0)
                a.wdata = 8'($urandom_range(0, RAM_BANKS_DEF + 1));
        end else if (roll < 45) begin
            a.mode = MODE_READ;
            a.addr = 16'($urandom_range(0, ADDR_ROMHI_END));
        end else if (roll < 65) begin
            a.mode = MODE_READ;
            a.addr = 16'($urandom_range(ADDR_ROMHI_END + 1, ADDR_ROM1_END));
        end else if (roll < 80) begin
            a.mode = MODE_READ;
            a.addr = ADDR_RAM_START | 16'(off);
        end else if (roll < 92) begin
            a.addr = ADDR_RAM_START | 16'(off);
        end else begin
            a.mode = 1'($urandom_range(0, 1));
            a.addr = 16'($urandom_range(0, 65535));
        end
        // never read a RAM byte that holds nothing yet: store to it instead
        if (a.mode == MODE_READ && in_ram_window(a.addr) && ram_ready()
                && !ram_written[ram_slot(a.addr)])
            a.mode = MODE_WRITE;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Check results, predict accepted items and track register writes.
    always @(posedge aclk) begin
        bus_result_t got;
        bus_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                got.read_data   = m_tdata[7:0];
                got.rom_address = m_tdata[30:8];
                got.rumble_on   = m_tdata[31];
                got.rom_fetch   = m_tuser;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(got), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
                    if (got.rom_fetch !== want.rom_fetch)
                        report_mismatch("rom_fetch", 32'(got.rom_fetch), 32'(want.rom_fetch));
                    if (got.rom_address !== want.rom_address)
                        report_mismatch("rom_address", 32'(got.rom_address),
                                        32'(want.rom_address));
                    if (got.rumble_on !== want.rumble_on)
                        report_mismatch("rumble_on", 32'(got.rumble_on), 32'(want.rumble_on));
                end
            end
            if (s_tvalid && s_tready) begin
                n_items++;
                want = map_access('{mode: s_tuser, addr: s_tdata[15:0], wdata: s_tdata[23:16]});
                pending_results.push_back(cur_typed ? cur_want : want);
            end
            if (psel && penable && pwrite && pready) begin
                n_cfg_writes++;
                set_register(paddr[3:2], pwdata);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: stall patterns that change now and then, plus a requested long hold.
    always @(negedge aclk) begin
        rx_phase++;
        if (hold_off_req) begin
            hold_left    = LONG_HOLD;
            hold_off_req = 1'b0;
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(64, 256);
        end else begin
            stall_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_phase[2];
            endcase
        end
    end

    // Offer one item and hold it until taken; a fresh one is drawn at the drive edge.
    task automatic send_access(input bit fresh, input bus_access_t a, input bit typed,
                               input bus_result_t want);
        bus_access_t item;
        @(negedge aclk);
        item = fresh ? pick_access() : a;
        s_tvalid  <= 1'b1;
        s_tdata   <= {item.wdata, item.addr};
        s_tuser   <= item.mode;
        cur_typed <= typed;
        cur_want  <= want;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic drain();
        idle_sender(1);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        drain();
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mapping(input int unsigned rom, input int unsigned ram,
                               input bit rumble);
        cfg_write(REG_ROM_BANK_COUNT, 32'(rom));
        cfg_write(REG_RAM_BANK_COUNT, 32'(ram));
        cfg_write(REG_HAS_RUMBLE, 32'(rumble));
    endtask

    task automatic add_access(input logic mode, input logic [15:0] addr,
                              input logic [7:0] wdata, input bit typed,
                              input logic [7:0] rd, input logic fetch,
                              input logic [22:0] raddr, input logic rumble);
        stim_row_t row;
        row.kind    = ROW_ACCESS;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.acc     = '{mode: mode, addr: addr, wdata: wdata};
        row.typed   = typed;
        row.want    = '{read_data: rd, rom_fetch: fetch, rom_address: raddr, rumble_on: rumble};
        directed.push_back(row);
    endtask

    task automatic add_config(input logic [1:0] idx, input logic [31:0] val);
        stim_row_t row;
        row.kind    = ROW_CONFIG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.acc     = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        directed.push_back(row);
    endtask

    task automatic run_phase(input int unsigned items, input bit with_hold,
                             input bit with_pause);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < items) begin
            burst = $urandom_range(1, 40);
            for (int unsigned i = 0; i < burst && sent < items; i++) begin
                send_access(1'b1, '0, 1'b0, '0);
                sent++;
                if (with_hold && sent == items / 4)
                    hold_off_req = 1'b1;
                if (with_pause && sent == items / 2)
                    drain();
            end
            if ($urandom_range(0, 9) >= 3)
                idle_sender($urandom_range(1, 12));
        end
    endtask

    initial begin
        int unsigned rom_set [PHASES];
        int unsigned ram_set [PHASES];
        bit          rumble_set [PHASES];
        aclk         = 1'b0;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = MODE_READ;
        m_tready     = 1'b0;
        cur_typed    = 1'b0;
        cur_want     = '0;
        hold_off_req = 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        stall_mode   = 0;
        rx_phase     = 0;
        idle_cycles  = 0;
        reset_mapping();
        hot_offsets[0] = '0;
        hot_offsets[1] = 13'h1FFF;
        for (int i = 2; i < HOT_SLOTS; i++)
            hot_offsets[i] = 13'($urandom);

        // after reset: ROM bank 1 mapped, two banks, no RAM, no rumble
        add_access(MODE_READ,  16'h0000, 8'h00, 1, 8'h00, 1, 23'h000000, 0);
        add_access(MODE_READ,  16'h3FFF, 8'hFF, 1, 8'h00, 1, 23'h003FFF, 0);
        add_access(MODE_READ,  16'h4000, 8'h00, 1, 8'h00, 1, 23'h004000, 0);
        add_access(MODE_READ,  16'h7FFF, 8'h00, 1, 8'h00, 1, 23'h007FFF, 0);
        add_access(MODE_READ,  16'h8000, 8'h00, 1, OPEN_BUS, 0, '0, 0);
        add_access(MODE_READ,  16'hFFFF, 8'h00, 1, OPEN_BUS, 0, '0, 0);
        add_access(MODE_READ,  16'hA000, 8'h00, 1, OPEN_BUS, 0, '0, 0);
        add_access(MODE_WRITE, 16'h2000, 8'h02, 0, '0, 0, '0, 0);
        // banked ROM beyond the cartridge size
        add_access(MODE_READ,  16'h4000, 8'h00, 1, OPEN_BUS, 0, '0, 0);
        add_config(REG_ROM_BANK_COUNT, 32'd512);
        add_config(REG_RAM_BANK_COUNT, 32'd16);
        add_config(REG_HAS_RUMBLE, 32'd1);
        // top bank, last byte of the ROM space
        add_access(MODE_WRITE, 16'h3FFF, 8'hFF, 0, '0, 0, '0, 0);
        add_access(MODE_WRITE, 16'h2FFF, 8'hFF, 0, '0, 0, '0, 0);
        add_access(MODE_READ,  16'h7FFF, 8'h00, 1, 8'h00, 1, 23'h7FFFFF, 0);
        add_access(MODE_WRITE, 16'h1FFF, 8'hFA, 0, '0, 0, '0, 0);
        add_access(MODE_WRITE, 16'h4000, 8'h0F, 1, 8'h00, 0, '0, 1);
        add_access(MODE_WRITE, 16'hBFFF, 8'h5A, 0, '0, 0, '0, 0);
        add_access(MODE_READ,  16'hBFFF, 8'h00, 1, 8'h5A, 0, '0, 1);
        // RAM bank past the limit drops the motor and reads open bus
        add_access(MODE_WRITE, 16'h5FFF, 8'h10, 0, '0, 0, '0, 0);
        add_access(MODE_READ,  16'hA000, 8'h00, 1, OPEN_BUS, 0, '0, 0);
        add_access(MODE_WRITE, 16'h5FFF, 8'h0F, 0, '0, 0, '0, 0);
        add_access(MODE_WRITE, 16'h0000, 8'h0B, 0, '0, 0, '0, 0);
        add_access(MODE_READ,  16'hBFFF, 8'h00, 1, OPEN_BUS, 0, '0, 1);
        add_access(MODE_WRITE, 16'h6000, 8'hFF, 0, '0, 0, '0, 0);
        add_access(MODE_WRITE, 16'h9FFF, 8'h00, 0, '0, 0, '0, 0);
        add_config(REG_HAS_RUMBLE, 32'd0);
        add_access(MODE_READ,  16'h0000, 8'h00, 1, 8'h00, 1, 23'h000000, 0);
        add_access(MODE_WRITE, 16'h2000, 8'h00, 0, '0, 0, '0, 0);
        add_access(MODE_READ,  16'h4000, 8'h00, 1, 8'h00, 1, 23'h400000, 0);

        rom_set    = '{512, 2, 2, 512, 100, 0, 0, 0, 0, 0};
        ram_set    = '{16, 0, 16, 1, 8, 0, 0, 0, 0, 0};
        rumble_set = '{1, 0, 1, 0, 1, 0, 0, 0, 0, 0};
        for (int i = 5; i < PHASES; i++) begin
            rom_set[i]    = $urandom_range(2, 512);
            ram_set[i]    = $urandom_range(0, 16);
            rumble_set[i] = 1'($urandom_range(0, 1));
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CONFIG)
                cfg_write(directed[i].reg_idx, directed[i].reg_val);
            else
                send_access(1'b0, directed[i].acc, directed[i].typed, directed[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_mapping(rom_set[p], ram_set[p], rumble_set[p]);
            run_phase(PHASE_ITEMS, p == 2, p == 3);
        end

        drain();
        $display("covered %0d accesses, %0d results, %0d register writes over %0d settings",
                 n_items, n_results, n_cfg_writes, PHASES + 3);
        $display("ROM fetches %0d, RAM bytes read back %0d, open-bus reads %0d",
                 n_fetches, n_ram_data, n_open_bus);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
